@@ sv/sst_pkg.sv @@
// sst_pkg: constants, codes and item types shared by the sorted site table.
// No dependencies.
package sst_pkg;

	localparam int CAPACITY       = 64;
	localparam int SITE_BITS      = 20;
	localparam int CNT_BITS       = $clog2(CAPACITY + 1);
	localparam int OPERAND_BITS   = 20;
	localparam int OUT_COUNT_BITS = 7;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_TEST   = 2'd2;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_BAD_RANK = 2'd1;
	localparam logic [1:0] STATUS_FULL     = 2'd2;

	typedef struct packed {
		logic [1:0]              cmd;
		logic [OPERAND_BITS-1:0] operand_value;
	} item_t;

	typedef struct packed {
		logic                      site_empty;
		logic [OUT_COUNT_BITS-1:0] entry_count;
		logic [1:0]                status;
	} result_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} sst_ctrl_t;

endpackage

@@ sv/sst_ctrl.sv @@
// sst_ctrl: two-state sequencer and handshake control of the sorted site table.
// Depends on sst_pkg.
module sst_ctrl
	import sst_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	output logic      result_valid,
	input  logic      result_stall,
	output sst_ctrl_t ctrl
);

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_UPDATE = 1'b1;

	logic state_q;
	logic state_d;
	logic valid_q;
	logic out_free;

	assign out_free     = !valid_q || !result_stall;
	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = valid_q;

	always_comb begin
		ctrl.capture = 1'b0;
		ctrl.commit  = 1'b0;
		state_d      = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					ctrl.capture = 1'b1;
					state_d      = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (out_free) begin
					ctrl.commit = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.commit) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ sv/sst_datapath.sv @@
// sst_datapath: row of compare-and-shift cells, entry count and result register.
// Depends on sst_pkg.
module sst_datapath
	import sst_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  sst_ctrl_t ctrl,
	input  item_t     item,
	output result_t   result
);

	logic [SITE_BITS-1:0] cell_q [CAPACITY];
	logic [SITE_BITS-1:0] cell_d [CAPACITY];
	logic [CNT_BITS-1:0]  count_q;
	logic [CNT_BITS-1:0]  count_d;

	logic [CAPACITY-1:0]  gt_q, eq_q, dsh_q;
	logic [CAPACITY-1:0]  gt_d, eq_d, dsh_d;
	logic [1:0]           cmd_q;
	logic [SITE_BITS-1:0] site_q;
	logic                 full_q;
	logic                 bad_q;
	logic [SITE_BITS-1:0] site_d;
	logic                 full_d;
	logic                 bad_d;
	result_t              result_q;
	result_t              result_d;

	// compare every cell against the incoming item
	always_comb begin
		site_d = SITE_BITS'(item.operand_value);
		full_d = int'(count_q) >= CAPACITY;
		bad_d  = (item.operand_value == '0) || (int'(item.operand_value) > int'(count_q));
		for (int k = 0; k < CAPACITY; k++) begin
			gt_d[k]  = (k < int'(count_q)) && (cell_q[k] > site_d);
			eq_d[k]  = (k < int'(count_q)) && (cell_q[k] == site_d);
			dsh_d[k] = (k < CAPACITY - 1) && ((k + 1) < int'(count_q))
				&& ((k + 1) >= int'(item.operand_value));
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			gt_q   <= gt_d;
			eq_q   <= eq_d;
			dsh_q  <= dsh_d;
			cmd_q  <= item.cmd;
			site_q <= site_d;
			full_q <= full_d;
			bad_q  <= bad_d;
		end
	end

	// shift cells and form the result
	always_comb begin
		count_d             = count_q;
		result_d.site_empty = 1'b0;
		result_d.status     = STATUS_OK;
		for (int k = 0; k < CAPACITY; k++) begin
			cell_d[k] = cell_q[k];
		end
		case (cmd_q)
			CMD_INSERT: begin
				if (full_q) begin
					result_d.status = STATUS_FULL;
				end else begin
					count_d = count_q + CNT_BITS'(1);
					for (int k = 0; k < CAPACITY; k++) begin
						if (k > 0 && gt_q[(k == 0) ? 0 : k - 1]) begin
							cell_d[k] = cell_q[(k == 0) ? 0 : k - 1];
						end else if (gt_q[k] || (k == int'(count_q))) begin
							cell_d[k] = site_q;
						end
					end
				end
			end
			CMD_DELETE: begin
				if (bad_q) begin
					result_d.status = STATUS_BAD_RANK;
				end else begin
					count_d = count_q - CNT_BITS'(1);
					for (int k = 0; k < CAPACITY; k++) begin
						if (dsh_q[k]) begin
							cell_d[k] = cell_q[(k == CAPACITY - 1) ? k : k + 1];
						end
					end
				end
			end
			CMD_TEST: begin
				result_d.site_empty = ~|eq_q;
			end
			default: begin
			end
		endcase
		result_d.entry_count = OUT_COUNT_BITS'(count_d);
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			for (int k = 0; k < CAPACITY; k++) begin
				cell_q[k] <= cell_d[k];
			end
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.commit) begin
			count_q <= count_d;
		end
	end

	assign result = result_q;

endmodule

@@ sv/sorted_site_table.sv @@
// sorted_site_table: ascending sorted table of sites with insert, delete by rank, test.
// Depends on sst_pkg, sst_ctrl, sst_datapath.
//
//   channel  payload   handshake                   width
//   item     item_t    item_valid / item_stall     22
//   result   result_t  result_valid / result_stall 10
//
// Each item is first compared against all cells, and the cells are then shifted when the item is committed.
// A new item is not accepted until the previous one is committed; a commit waits for a free result register.
// Reset empties the table at once; cell contents are not cleared.
// A stalled result holds the update of the next item until the result is taken.
module sorted_site_table
	import sst_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	sst_ctrl_t ctrl;

	sst_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.ctrl         (ctrl)
	);

	sst_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.item   (item),
		.result (result)
	);

endmodule
